@@ rtl/core/wtr_pkg.sv @@
// ----------------------------------------------------------------------------
// wtr_pkg
// shared types, codes and the sample blend for the window table resampler
// ----------------------------------------------------------------------------
package wtr_pkg;

  // default stored half-window length
  localparam int StoredLenDefault = 1024;

  // arithmetic width for index math (covers 4 * 4096 and 2^15)
  localparam int CalcW = 17;

  // width of a store index field in a queue entry (stored length up to 4096)
  localparam int StoreIdxW = 12;

  // front-to-back queue depth
  localparam int QueueDepth = 2;

  localparam int SampleW = 12;
  localparam int WordW   = 32;

  // configuration register indexes
  localparam logic REG_WINDOW_TYPE = 1'b0;
  localparam logic REG_FFT_LOG2    = 1'b1;

  // window type codes
  localparam logic [1:0] WIN_RECT    = 2'd0;
  localparam logic [1:0] WIN_HAMMING = 2'd1;

  // table select codes
  localparam logic TAB_HAMMING = 1'b0;
  localparam logic TAB_HANNING = 1'b1;

  localparam logic CMD_LOAD = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BYPASS      = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_BLEND  = 2'd1,
    KIND_RAW    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  // one classified request as it travels from front to back
  typedef struct packed {
    kind_e                 kind;
    logic                  tsel;
    logic [StoreIdxW-1:0]  addr_a;
    logic [StoreIdxW-1:0]  addr_b;
    logic [WordW-1:0]      wdata;
    status_e               status;
  } entry_t;

  // 3/4 of the current sample plus 1/4 of the neighbour, each rounded,
  // copied into both packed halves
  function automatic logic [WordW-1:0] blend_word(logic [SampleW-1:0] cur,
                                                  logic [SampleW-1:0] nb);
    logic [SampleW+1:0] three_q;
    logic [SampleW+1:0] one_q;
    logic [SampleW+1:0] sum;
    three_q = ({2'b00, cur} + {1'b0, cur, 1'b0} + (SampleW+2)'(2)) >> 2;
    one_q   = ({2'b00, nb} + (SampleW+2)'(2)) >> 2;
    sum     = three_q + one_q;
    return {(WordW - 2*SampleW)'(0), sum[SampleW-1:0], sum[SampleW-1:0]};
  endfunction

endpackage

@@ rtl/core/wtr_front.sv @@
// ----------------------------------------------------------------------------
// wtr_front
// classifies each request and works out the store addresses it needs
// ----------------------------------------------------------------------------
module wtr_front #(
  parameter int STORED_LEN = wtr_pkg::StoredLenDefault
) (
  input  logic                    accept_i,
  input  logic                    cmd_i,
  input  logic                    table_sel_i,
  input  logic [9:0]              entry_index_i,
  input  logic [31:0]             entry_word_i,
  input  logic [11:0]             out_index_i,
  input  logic [1:0]              window_type_i,
  input  logic [3:0]              fft_log2_i,
  output logic                    push_o,
  output wtr_pkg::entry_t         entry_o
);
  import wtr_pkg::*;

  localparam logic [CalcW-1:0] SLen = CalcW'(STORED_LEN);
  localparam logic [CalcW-1:0] One  = CalcW'(1);

  logic [CalcW-1:0] n_len;
  logic [CalcW-1:0] d_idx;
  logic [CalcW-1:0] half_len;
  logic [CalcW-1:0] pos;
  logic [CalcW-1:0] pair;
  logic [CalcW-1:0] cur;
  logic [CalcW-1:0] nb;
  logic [CalcW-1:0] step;
  logic [CalcW-1:0] per_pass;
  logic [CalcW-1:0] rel;
  logic [CalcW-1:0] raw_idx;
  logic [26:0]      prod;
  logic             rev;
  logic             use_next;
  logic             lower;
  logic             blend_mode;
  logic             raw_mode;

  always_comb begin
    n_len      = One << fft_log2_i;
    d_idx      = CalcW'(out_index_i) & (n_len - One);
    half_len   = SLen << 1;
    blend_mode = (n_len == (SLen << 2));
    raw_mode   = (n_len <= half_len) && ((half_len & (n_len - One)) == '0);

    // interpolating mode: forward pass then reverse pass, two entries a word
    rev      = (d_idx >= half_len);
    pos      = rev ? (d_idx - half_len) : d_idx;
    pair     = pos >> 1;
    use_next = pos[0];
    if (!rev) begin
      cur = pair;
      if (use_next) begin
        nb = ((pair + One) < SLen) ? (pair + One) : pair;
      end else begin
        nb = (pair != '0) ? (pair - One) : pair;
      end
    end else begin
      cur = SLen - One - pair;
      if (use_next) begin
        nb = (cur != '0) ? (cur - One) : cur;
      end else begin
        nb = ((cur + One) < SLen) ? (cur + One) : cur;
      end
    end

    // decimating mode: every step-th word, forward then backward
    step     = half_len >> fft_log2_i;
    per_pass = (n_len == One) ? One : (n_len >> 1);
    lower    = (d_idx < per_pass);
    rel      = lower ? d_idx : (d_idx - per_pass);
    prod     = {14'd0, rel[12:0]} * {13'd0, step[13:0]};
    raw_idx  = lower ? prod[CalcW-1:0] : (SLen - One - prod[CalcW-1:0]);
    if (raw_idx >= SLen) begin
      raw_idx = SLen - One;
    end
  end

  always_comb begin
    entry_o        = '0;
    entry_o.kind   = KIND_STATUS;
    entry_o.status = STATUS_OK;
    entry_o.wdata  = entry_word_i;
    push_o         = 1'b0;
    if (cmd_i == CMD_LOAD) begin
      entry_o.kind   = KIND_WRITE;
      entry_o.tsel   = table_sel_i;
      entry_o.addr_a = StoreIdxW'(entry_index_i);
      // loads past the table end are dropped
      push_o         = accept_i && (CalcW'(entry_index_i) < SLen);
    end else begin
      push_o       = accept_i;
      entry_o.tsel = (window_type_i == WIN_HAMMING) ? TAB_HAMMING : TAB_HANNING;
      if (window_type_i == WIN_RECT) begin
        entry_o.status = STATUS_BYPASS;
      end else if (blend_mode) begin
        entry_o.kind   = KIND_BLEND;
        entry_o.addr_a = cur[StoreIdxW-1:0];
        entry_o.addr_b = nb[StoreIdxW-1:0];
      end else if (raw_mode) begin
        entry_o.kind   = KIND_RAW;
        entry_o.addr_a = raw_idx[StoreIdxW-1:0];
      end else begin
        entry_o.status = STATUS_UNSUPPORTED;
      end
    end
  end

endmodule

@@ rtl/core/wtr_queue.sv @@
// ----------------------------------------------------------------------------
// wtr_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module wtr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wtr_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output wtr_pkg::entry_t  entry_o
);
  import wtr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t            slots_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(QueueDepth));
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/wtr_back.sv @@
// ----------------------------------------------------------------------------
// wtr_back
// carries out queued requests on the single-port window store
// ----------------------------------------------------------------------------
module wtr_back #(
  parameter int STORED_LEN = wtr_pkg::StoredLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  wtr_pkg::entry_t  q_entry_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [31:0]      window_value_o,
  output logic [1:0]       status_o
);
  import wtr_pkg::*;

  localparam int AddrW = $clog2(STORED_LEN);
  localparam int MemW  = AddrW + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RAW  = 4'b0010,
    ST_BA   = 4'b0100,
    ST_BB   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  entry_t              job_q;
  logic                job_load;
  logic [WordW-1:0]    mem_q [2**MemW];
  logic [WordW-1:0]    rdata_q;
  logic [SampleW-1:0]  a_q;
  logic                mem_we;
  logic                mem_re;
  logic [MemW-1:0]     mem_addr;
  logic                valid_q, valid_d;
  logic [WordW-1:0]    value_q, value_d;
  logic [1:0]          status_q, status_d;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    job_load = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = {q_entry_i.tsel, q_entry_i.addr_a[AddrW-1:0]};
    valid_d  = 1'b0;
    value_d  = value_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o    = 1'b1;
          job_load = 1'b1;
          case (q_entry_i.kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
            end
            KIND_STATUS: begin
              valid_d  = 1'b1;
              value_d  = '0;
              status_d = q_entry_i.status;
            end
            KIND_RAW: begin
              mem_re  = 1'b1;
              state_d = ST_RAW;
            end
            KIND_BLEND: begin
              mem_re  = 1'b1;
              state_d = ST_BA;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RAW: begin
        valid_d  = 1'b1;
        value_d  = rdata_q;
        status_d = STATUS_OK;
        state_d  = ST_IDLE;
      end
      ST_BA: begin
        // neighbour read while the current word is captured
        mem_re   = 1'b1;
        mem_addr = {job_q.tsel, job_q.addr_b[AddrW-1:0]};
        state_d  = ST_BB;
      end
      ST_BB: begin
        valid_d  = 1'b1;
        value_d  = blend_word(a_q, rdata_q[SampleW-1:0]);
        status_d = STATUS_OK;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    if (job_load) begin
      job_q <= q_entry_i;
    end
    if (state_q == ST_BA) begin
      a_q <= rdata_q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= q_entry_i.wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign result_valid_o = valid_q;
  assign window_value_o = value_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  a_blend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BB |=> valid_q)
    else $error("blend read finished without a result");

  a_raw_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RAW |=> valid_q)
    else $error("raw read finished without a result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_RAW || state_q == ST_BB ||
                      (pop_o && q_entry_i.kind == KIND_STATUS)))
    else $error("result strobe without a finished request");
`endif

endmodule

@@ rtl/core/window_table_resampler.sv @@
// ----------------------------------------------------------------------------
// window_table_resampler
// symmetric window table with interpolation and decimation for fft lengths
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy              cmd, table_sel, entry_index,
//                                                  entry_word, out_index
//  result    out        result_valid_o, 1 cycle    window_value_o, status_o
//  config    in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  flow: the front classifies a request in its accept cycle and it waits in
//  the queue, then the back writes a load, reads the store once for a
//  decimated read and twice for an interpolated read (single-port store),
//  and answers a bypass or unsupported read without a store read
//  busy rises when the two-entry request queue is full
//  reset clears control and config only; the store is undefined until loaded
//  the receiver cannot stall: each result strobe lasts exactly one cycle
//
module window_table_resampler #(
  parameter int STORED_LEN = wtr_pkg::StoredLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic        table_sel_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] entry_word_i,
  input  logic [11:0] out_index_i,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  // result channel
  output logic        result_valid_o,
  output logic [31:0] window_value_o,
  output logic [1:0]  status_o
);
  import wtr_pkg::*;

  // config registers
  logic [1:0]  window_type_q;
  logic [3:0]  fft_log2_q;

  // front to queue
  logic        accept;
  logic        push;
  entry_t      front_entry;

  // queue to back
  logic        q_valid;
  logic        q_full;
  logic        pop;
  entry_t      q_entry;

  // a request is taken whenever the queue has room
  assign busy   = q_full;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_type_q <= WIN_RECT;
      fft_log2_q    <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_TYPE: window_type_q <= cfg_data_i[1:0];
        REG_FFT_LOG2:    fft_log2_q    <= cfg_data_i;
        default: begin
          window_type_q <= window_type_q;
        end
      endcase
    end
  end

  // classify and compute store addresses
  wtr_front #(
    .STORED_LEN(STORED_LEN)
  ) u_front (
    .accept_i      (accept),
    .cmd_i         (cmd_i),
    .table_sel_i   (table_sel_i),
    .entry_index_i (entry_index_i),
    .entry_word_i  (entry_word_i),
    .out_index_i   (out_index_i),
    .window_type_i (window_type_q),
    .fft_log2_i    (fft_log2_q),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  // decouples the front from the store sequencer
  wtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .entry_o (q_entry)
  );

  // store writes, reads and the interpolating blend
  wtr_back #(
    .STORED_LEN(STORED_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .window_value_o (window_value_o),
    .status_o       (status_o)
  );

endmodule

@@ test/window_entry_checker.sv @@
// ----------------------------------------------------------------------------
// window_entry_checker
// watches the request, config and result channels of the window table
// resampler, keeps its own copy of both half-window stores and the window
// settings, predicts each read and compares every result in order
// ----------------------------------------------------------------------------
module window_entry_checker #(
  parameter int StoredLen = wtr_pkg::StoredLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        cmd_i,
  input  logic        table_sel_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] entry_word_i,
  input  logic [11:0] out_index_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        result_valid_o,
  input  logic [31:0] window_value_o,
  input  logic [1:0]  status_o,
  output int          pending_o,
  output int          errors_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import wtr_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } window_entry_t;

  window_entry_t expected_entries[$];
  logic [31:0]   hamming_words[StoredLen];
  logic [31:0]   hanning_words[StoredLen];
  logic [1:0]    win_type;
  logic [3:0]    log2_len;
  int            mismatches = 0;

  function automatic logic [31:0] stored_word(int unsigned addr);
    return (win_type == WIN_HAMMING) ? hamming_words[addr] : hanning_words[addr];
  endfunction

  // rounded three quarters of the current sample plus rounded quarter of the
  // neighbour, placed in both 12-bit halves
  function automatic logic [31:0] blend_samples(logic [31:0] cur_w, logic [31:0] nb_w);
    int unsigned mix;
    mix = ((cur_w[11:0] * 3 + 2) >> 2) + ((nb_w[11:0] + 2) >> 2);
    return {8'h00, mix[11:0], mix[11:0]};
  endfunction

  function automatic window_entry_t predict_window_entry(logic [11:0] oi);
    window_entry_t e;
    int unsigned   n;
    int unsigned   d;
    int unsigned   p;
    int unsigned   cur;
    int unsigned   nb;
    int unsigned   stride;
    int unsigned   per_pass;
    int            idx;
    logic          rev;
    logic          odd;
    e.value  = '0;
    e.status = STATUS_OK;
    n = 1 << log2_len;
    d = oi & (n - 1);
    if (win_type == WIN_RECT) begin
      e.status = STATUS_BYPASS;
    end else if (n == 4 * StoredLen) begin
      rev = (d >= 2 * StoredLen);
      p   = rev ? d - 2 * StoredLen : d;
      odd = p[0];
      cur = rev ? StoredLen - 1 - (p >> 1) : (p >> 1);
      // neighbour ahead in the direction of travel on odd slots, behind on even
      if (odd ^ rev) begin
        nb = (cur + 1 < StoredLen) ? cur + 1 : cur;
      end else begin
        nb = (cur > 0) ? cur - 1 : cur;
      end
      e.value = blend_samples(stored_word(cur), stored_word(nb));
    end else if (n <= 2 * StoredLen && (2 * StoredLen) % n == 0) begin
      stride   = (2 * StoredLen) / n;
      per_pass = (StoredLen + stride - 1) / stride;
      if (d < per_pass) begin
        idx = int'(d * stride);
      end else begin
        idx = StoredLen - 1 - int'((d - per_pass) * stride);
      end
      if (idx < 0 || idx >= StoredLen) idx = StoredLen - 1;
      e.value = stored_word(idx);
    end else begin
      e.status = STATUS_UNSUPPORTED;
    end
    return e;
  endfunction

  always @(posedge clk_i) begin : monitor
    window_entry_t exp_e;
    if (!rst_ni) begin
      win_type = WIN_RECT;
      log2_len = 4'd10;
      expected_entries.delete();
    end else begin
      // results first: a result at this edge belongs to an older request
      if (result_valid_o === 1'b1) begin
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result %h status %0d with no read outstanding",
                     $realtime, window_value_o, status_o);
        end else begin
          exp_e = expected_entries.pop_front();
          if (window_value_o !== exp_e.value || status_o !== exp_e.status) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: read mismatch window_value exp %h got %h, status exp %0d got %0d",
                       $realtime, exp_e.value, window_value_o, exp_e.status, status_o);
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == REG_WINDOW_TYPE) win_type = cfg_data_i[1:0];
        else if (cfg_idx_i == REG_FFT_LOG2) log2_len = cfg_data_i;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (cmd_i == CMD_LOAD) begin
          if (table_sel_i == TAB_HAMMING) hamming_words[entry_index_i] = entry_word_i;
          else hanning_words[entry_index_i] = entry_word_i;
        end else begin
          expected_entries.push_back(predict_window_entry(out_index_i));
        end
      end
    end
    pending_o <= expected_entries.size();
    errors_o  <= mismatches;
  end

endmodule

@@ test/tb_window_table_resampler.sv @@
// ----------------------------------------------------------------------------
// tb_window_table_resampler
// fills both half-window stores, runs directed reads over every window type
// and fft size class, then random mixes of loads and reads under random
// settings; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_window_table_resampler;

  timeunit 1ns;
  timeprecision 1ps;

  import wtr_pkg::*;

  // codes the package leaves out
  localparam logic       CMD_READ          = 1'b1;
  localparam logic [1:0] WIN_HANNING       = 2'd2;
  localparam logic [1:0] WIN_HANNING_ALIAS = 2'd3;

  localparam int StoredLen     = StoredLenDefault;
  localparam int RandomItems   = 1200;
  // front, queue of two and the slowest back-end pass, with margin
  localparam int DrainCycles   = 16;
  // cycles with no accepted request and no result before giving up
  localparam int WatchdogLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = CMD_LOAD;
  logic        table_sel_i = TAB_HAMMING;
  logic [9:0]  entry_index_i = '0;
  logic [31:0] entry_word_i = '0;
  logic [11:0] out_index_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_WINDOW_TYPE;
  logic [3:0]  cfg_data_i = '0;
  logic        result_valid_o;
  logic [31:0] window_value_o;
  logic [1:0]  status_o;

  int          pending;
  int          errors;

  // stimulus bookkeeping
  logic        steady = 1'b0;
  logic [1:0]  cur_type = WIN_RECT;
  logic [3:0]  cur_log2 = 4'd10;
  int          loads_sent = 0;
  int          reads_sent = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  window_table_resampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .table_sel_i   (table_sel_i),
    .entry_index_i (entry_index_i),
    .entry_word_i  (entry_word_i),
    .out_index_i   (out_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .window_value_o(window_value_o),
    .status_o      (status_o)
  );

  window_entry_checker #(
    .StoredLen(StoredLen)
  ) entry_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .table_sel_i   (table_sel_i),
    .entry_index_i (entry_index_i),
    .entry_word_i  (entry_word_i),
    .out_index_i   (out_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .window_value_o(window_value_o),
    .status_o      (status_o),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  // mostly back to back, often a short pause, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold the request until the block takes it, then maybe pause
  task automatic issue(logic cmd, logic tsel, logic [9:0] eidx, logic [31:0] word,
                       logic [11:0] oi);
    int unsigned gap;
    start         <= 1'b1;
    cmd_i         <= cmd;
    table_sel_i   <= tsel;
    entry_index_i <= eidx;
    entry_word_i  <= word;
    out_index_i   <= oi;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (cmd == CMD_LOAD) loads_sent++;
    else reads_sent++;
    gap = pick_gap();
    // start stays high when the next request follows at once
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // unused fields carry noise so the block must ignore them
  task automatic load_word(logic tsel, logic [9:0] eidx, logic [31:0] word);
    issue(CMD_LOAD, tsel, eidx, word, 12'($urandom));
  endtask

  task automatic read_entry(logic [11:0] oi);
    issue(CMD_READ, 1'($urandom), 10'($urandom), $urandom, oi);
  endtask

  // settings change only with nothing in flight; loads give no result, so
  // wait out the pipeline after the last read returns
  task automatic program_window(logic [1:0] wt, logic [3:0] fl);
    logic [1:0] junk;
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    // upper data bits must be dropped by the 2-bit window type register
    junk = 2'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WINDOW_TYPE;
    cfg_data_i <= {junk, wt};
    @(posedge clk_i);
    cfg_idx_i  <= REG_FFT_LOG2;
    cfg_data_i <= fl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_type = wt;
    cur_log2 = fl;
    settings_used++;
  endtask

  // watchdog on forward progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || result_valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no request or result for %0d cycles, %0d reads outstanding",
                 WatchdogLimit, pending);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int          sent;
    int          phase_len;
    int unsigned r;
    int          hot;
    logic        hot_armed;
    logic        tsel;
    logic [9:0]  eidx;
    logic [11:0] oi;
    logic [1:0]  wt;
    logic [3:0]  fl;

    sent      = 0;
    hot       = 0;
    hot_armed = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill both stores so no read ever touches an unwritten entry
    for (int i = 0; i < StoredLen; i++) begin
      load_word(TAB_HAMMING, 10'(i), $urandom);
      load_word(TAB_HANNING, 10'(i), $urandom);
    end

    // full-scale and zero samples side by side at both hamming table ends and the low hanning end
    load_word(TAB_HAMMING, 10'd0, 32'hFFFF_FFFF);
    load_word(TAB_HAMMING, 10'd1, 32'h0000_0000);
    load_word(TAB_HAMMING, 10'd1022, 32'hFFFF_FFFF);
    load_word(TAB_HAMMING, 10'd1023, 32'h0000_0000);
    load_word(TAB_HANNING, 10'd0, 32'h0000_0000);
    load_word(TAB_HANNING, 10'd1, 32'hFFFF_FFFF);
    load_word(TAB_HANNING, 10'd1023, 32'hFFFF_FFFF);

    // interpolation: both passes, both slot parities, clamped ends
    program_window(WIN_HAMMING, 4'd12);
    read_entry(12'd0);
    read_entry(12'd1);
    read_entry(12'd2);
    read_entry(12'd2047);
    read_entry(12'd2048);
    read_entry(12'd2049);
    read_entry(12'd4094);
    read_entry(12'd4095);
    // window type three reads the hanning table
    program_window(WIN_HANNING_ALIAS, 4'd12);
    read_entry(12'd1);
    read_entry(12'd4095);
    // straight copy with no decimation, both pass boundaries
    program_window(WIN_HANNING, 4'd11);
    read_entry(12'd0);
    read_entry(12'd1023);
    read_entry(12'd1024);
    read_entry(12'd2047);
    // length one, index folded modulo n
    program_window(WIN_HAMMING, 4'd0);
    read_entry(12'd4095);
    // length four: heavy decimation
    program_window(WIN_HANNING, 4'd2);
    read_entry(12'd0);
    read_entry(12'd3);
    // rectangular bypass and unsupported sizes
    program_window(WIN_RECT, 4'd7);
    read_entry(12'd5);
    program_window(WIN_HAMMING, 4'd13);
    read_entry(12'd9);
    program_window(WIN_HANNING, 4'd15);
    read_entry(12'd4095);

    // random phases: one setting each, mostly reads with loads mixed in
    while (sent < RandomItems) begin
      r  = $urandom_range(99);
      wt = (r < 10) ? WIN_RECT : 2'($urandom_range(1, 3));
      r  = $urandom_range(99);
      if (r < 40) fl = 4'd12;
      else if (r < 80) fl = 4'($urandom_range(1, 11));
      else if (r < 88) fl = 4'd0;
      else fl = 4'($urandom_range(13, 15));
      program_window(wt, fl);
      steady    = ($urandom_range(3) == 0);
      hot_armed = 1'b0;
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) begin
        if ($urandom_range(3) == 0) begin
          eidx = 10'($urandom);
          tsel = 1'($urandom);
          // sometimes rewrite an entry and, at fft_log2 11 or 12, aim the next read at it
          if ($urandom_range(2) == 0) begin
            hot       = eidx;
            hot_armed = 1'b1;
            tsel      = (cur_type == WIN_HAMMING) ? TAB_HAMMING : TAB_HANNING;
          end
          load_word(tsel, eidx, $urandom);
        end else begin
          r = $urandom_range(7);
          if (hot_armed && cur_log2 == 4'd12) begin
            oi = $urandom_range(1) ? 12'(2 * hot + $urandom_range(1))
                                   : 12'(2048 + 2 * (StoredLen - 1 - hot) + $urandom_range(1));
            hot_armed = 1'b0;
          end else if (hot_armed && cur_log2 == 4'd11) begin
            oi = 12'({1'($urandom), 1'b0, 10'(hot)});
            hot_armed = 1'b0;
          end else if (r == 0) begin
            // near the ends of either pass
            oi = 12'($urandom_range(1) * 2048 +
                     ($urandom_range(1) ? $urandom_range(0, 3) : 2047 - $urandom_range(0, 3)));
          end else begin
            oi = 12'($urandom);
          end
          read_entry(oi);
        end
        sent++;
      end
    end

    start  <= 1'b0;
    steady = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d loads and %0d reads over %0d window settings",
             loads_sent, reads_sent, settings_used);
    $display("window types 0 to 3, fft_log2 0 to 15, with random request gaps");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
